/* src/ipid_pkg.sv */
`default_nettype none

package ipid_pkg;

    // Datapath widths
    localparam int FRAC_SHIFT = 8;
    localparam int DATA_W     = 16;
    localparam int COEF_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int WEIGHT_W   = 9;
    localparam int NUM_TAPS   = 4;
    localparam int TAP_IDX_W  = 2;

    // APB register port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    // Serial multiplier sizing
    localparam int MC_W      = DATA_W + 1;
    localparam int FILT_BITS = (FRAC_SHIFT + 1 > WEIGHT_W) ? FRAC_SHIFT + 1 : WEIGHT_W;
    localparam int MUL_W     = (FILT_BITS > COEF_W) ? FILT_BITS : COEF_W;
    localparam int ACC_W     = ((DATA_W + FRAC_SHIFT + 2) > (DATA_W + COEF_W + 2)) ?
                               (DATA_W + FRAC_SHIFT + 2) : (DATA_W + COEF_W + 2);
    localparam int CNT_W     = $clog2(MUL_W + 1);
    localparam int Q_W       = ACC_W - FRAC_SHIFT;
    localparam int U_W       = Q_W + 1;

    // Reset values
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = {LIMIT_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd256;

    // Register map, in word order
    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0      = 3'd0,
        REG_B1      = 3'd1,
        REG_B2      = 3'd2,
        REG_B3      = 3'd3,
        REG_LIMIT   = 3'd4,
        REG_FILT_EN = 3'd5,
        REG_WEIGHT  = 3'd6
    } reg_idx_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [NUM_TAPS-1:0][COEF_W-1:0] coef;
        logic [LIMIT_W-1:0]              limit;
        logic                            filt_en;
        logic [WEIGHT_W-1:0]             weight;
    } cfg_t;

    // Command to the shift-add multiplier
    typedef struct packed {
        logic             start;
        logic             init;
        logic [ACC_W-1:0] acc_init;
        logic [MC_W-1:0]  mcand;
        logic [MUL_W-1:0] mplier;
        logic [CNT_W-1:0] nbits;
        logic             msb_neg;
    } mac_cmd_t;

    typedef struct packed {
        logic             busy;
        logic [ACC_W-1:0] acc;
    } mac_stat_t;

    // Finished result towards the output register
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] drive;
        logic              limited;
    } res_t;

endpackage

`default_nettype wire

/* src/ipid_regs.sv */
`default_nettype none

module ipid_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipid_pkg::PADDR_W-1:0] paddr,
    input  logic [ipid_pkg::PDATA_W-1:0] pwdata,
    output logic [ipid_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output ipid_pkg::cfg_t               cfg
);

    logic [ipid_pkg::NUM_TAPS-1:0][ipid_pkg::COEF_W-1:0] coef_reg, coef_next;
    logic [ipid_pkg::LIMIT_W-1:0]  limit_reg, limit_next;
    logic                          filt_en_reg, filt_en_next;
    logic [ipid_pkg::WEIGHT_W-1:0] weight_reg, weight_next;

    ipid_pkg::reg_idx_t                reg_idx;
    logic [ipid_pkg::TAP_IDX_W-1:0]    tap_sel;
    logic [ipid_pkg::COEF_W-1:0]       coef_rd;
    logic                              wr_en;

    assign reg_idx = ipid_pkg::reg_idx_t'(paddr[ipid_pkg::PADDR_W-1:2]);
    assign tap_sel = paddr[ipid_pkg::TAP_IDX_W+1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign coef_rd = coef_reg[tap_sel];

    // Write decode
    always_comb begin
        coef_next    = coef_reg;
        limit_next   = limit_reg;
        filt_en_next = filt_en_reg;
        weight_next  = weight_reg;
        if (wr_en) begin
            case (reg_idx)
                ipid_pkg::REG_B0, ipid_pkg::REG_B1,
                ipid_pkg::REG_B2, ipid_pkg::REG_B3: begin
                    coef_next[tap_sel] = pwdata[ipid_pkg::COEF_W-1:0];
                end
                ipid_pkg::REG_LIMIT: begin
                    limit_next = pwdata[ipid_pkg::LIMIT_W-1:0];
                end
                ipid_pkg::REG_FILT_EN: begin
                    filt_en_next = pwdata[0];
                end
                ipid_pkg::REG_WEIGHT: begin
                    weight_next = pwdata[ipid_pkg::WEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg    <= '0;
            limit_reg   <= ipid_pkg::LIMIT_RST;
            filt_en_reg <= 1'b0;
            weight_reg  <= ipid_pkg::WEIGHT_RST;
        end else begin
            coef_reg    <= coef_next;
            limit_reg   <= limit_next;
            filt_en_reg <= filt_en_next;
            weight_reg  <= weight_next;
        end
    end

    // Read mux; coefficients read back sign-extended
    always_comb begin
        case (reg_idx)
            ipid_pkg::REG_B0, ipid_pkg::REG_B1,
            ipid_pkg::REG_B2, ipid_pkg::REG_B3: begin
                prdata = {{(ipid_pkg::PDATA_W-ipid_pkg::COEF_W){coef_rd[ipid_pkg::COEF_W-1]}},
                          coef_rd};
            end
            ipid_pkg::REG_LIMIT:   prdata = ipid_pkg::PDATA_W'(limit_reg);
            ipid_pkg::REG_FILT_EN: prdata = ipid_pkg::PDATA_W'(filt_en_reg);
            ipid_pkg::REG_WEIGHT:  prdata = ipid_pkg::PDATA_W'(weight_reg);
            default:               prdata = '0;
        endcase
    end

    assign cfg.coef    = coef_reg;
    assign cfg.limit   = limit_reg;
    assign cfg.filt_en = filt_en_reg;
    assign cfg.weight  = weight_reg;

endmodule

`default_nettype wire

/* src/ipid_mac.sv */
`default_nettype none

// Bit-serial shift-add multiply-accumulate: one multiplier bit per cycle.
module ipid_mac (
    input  logic                aclk,
    input  logic                aresetn,
    input  ipid_pkg::mac_cmd_t  cmd,
    output ipid_pkg::mac_stat_t stat
);

    logic [ipid_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [ipid_pkg::ACC_W-1:0] mc_reg, mc_next;
    logic [ipid_pkg::MUL_W-1:0] mp_reg, mp_next;
    logic [ipid_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       neg_reg, neg_next;
    logic                       last_bit;

    // The sign bit of a two's-complement multiplier carries negative weight
    assign last_bit = (cnt_reg == ipid_pkg::CNT_W'(1));

    always_comb begin
        acc_next = acc_reg;
        mc_next  = mc_reg;
        mp_next  = mp_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (cmd.start) begin
            if (cmd.init) begin
                acc_next = cmd.acc_init;
            end
            mc_next  = {{(ipid_pkg::ACC_W-ipid_pkg::MC_W){cmd.mcand[ipid_pkg::MC_W-1]}},
                        cmd.mcand};
            mp_next  = cmd.mplier;
            cnt_next = cmd.nbits;
            neg_next = cmd.msb_neg;
        end else if (cnt_reg != '0) begin
            if (mp_reg[0]) begin
                if (neg_reg && last_bit) begin
                    acc_next = acc_reg - mc_reg;
                end else begin
                    acc_next = acc_reg + mc_reg;
                end
            end
            mc_next  = mc_reg << 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg - ipid_pkg::CNT_W'(1);
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            neg_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            neg_reg <= neg_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.acc  = acc_reg;

endmodule

`default_nettype wire

/* src/ipid_seq.sv */
`default_nettype none

// Step sequencer: error history, filter, four taps, scaling, accumulate, clamp.
module ipid_seq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [ipid_pkg::DATA_W-1:0] s_error_sample,
    input  ipid_pkg::cfg_t                    cfg,
    output ipid_pkg::mac_cmd_t                mac_cmd,
    input  ipid_pkg::mac_stat_t               mac_stat,
    output ipid_pkg::res_t                    res,
    input  logic                              res_ready
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FILT  = 7'b0000010,
        ST_ISSUE = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_ADD   = 7'b0100000,
        ST_CLAMP = 7'b1000000
    } state_t;

    localparam int DW = ipid_pkg::DATA_W;
    localparam int AW = ipid_pkg::ACC_W;
    localparam int UW = ipid_pkg::U_W;
    localparam int QW = ipid_pkg::Q_W;
    localparam logic [ipid_pkg::MUL_W-1:0] SCALE_M =
        ipid_pkg::MUL_W'(64'd1 << ipid_pkg::FRAC_SHIFT);
    localparam logic [AW-1:0] RND_BIAS = AW'((64'd1 << ipid_pkg::FRAC_SHIFT) - 64'd1);

    state_t                                        state_reg, state_next;
    logic [ipid_pkg::TAP_IDX_W-1:0]                tap_reg, tap_next;
    logic [ipid_pkg::NUM_TAPS-1:0][DW-1:0]         hist_reg, hist_next;
    logic [DW-1:0]                                 out_acc_reg, out_acc_next;
    logic [QW-1:0]                                 q_reg, q_next;
    logic [UW-1:0]                                 u_reg, u_next;

    logic [ipid_pkg::MUL_W-1:0] w_ext, w_eff;
    logic [AW-1:0]              filt_base;
    logic [ipid_pkg::MC_W-1:0]  diff;
    logic [DW-1:0]              tap_err;
    logic [ipid_pkg::COEF_W-1:0] tap_coef;
    logic [AW-1:0]              rnd;
    logic signed [AW-1:0]       q_full;
    logic [UW-1:0]              lim_u, lim_n, clamp_val;
    logic                       clip;

    // Smoothing weight, held at full scale when off or out of range
    assign w_ext = ipid_pkg::MUL_W'(cfg.weight);
    assign w_eff = (!cfg.filt_en || (w_ext > SCALE_M)) ? SCALE_M : w_ext;

    // ((F-w)*prev + w*err) rewritten as F*prev + w*(err-prev)
    assign filt_base = {{(AW-DW){hist_reg[0][DW-1]}}, hist_reg[0]} << ipid_pkg::FRAC_SHIFT;
    assign diff      = {s_error_sample[DW-1], s_error_sample} -
                       {hist_reg[0][DW-1], hist_reg[0]};

    assign tap_err  = hist_reg[tap_reg];
    assign tap_coef = cfg.coef[tap_reg];

    // Divide by the scale, truncating toward zero
    assign rnd    = mac_stat.acc + (mac_stat.acc[AW-1] ? RND_BIAS : '0);
    assign q_full = $signed(rnd) >>> ipid_pkg::FRAC_SHIFT;

    // Symmetric clamp
    assign lim_u = UW'(cfg.limit);
    assign lim_n = '0 - lim_u;
    always_comb begin
        clamp_val = u_reg;
        clip      = 1'b0;
        if ($signed(u_reg) > $signed(lim_u)) begin
            clamp_val = lim_u;
            clip      = 1'b1;
        end else if ($signed(u_reg) < $signed(lim_n)) begin
            clamp_val = lim_n;
            clip      = 1'b1;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        hist_next    = hist_reg;
        out_acc_next = out_acc_reg;
        q_next       = q_reg;
        u_next       = u_reg;
        mac_cmd      = '0;
        res.valid    = 1'b0;
        res.drive    = clamp_val[DW-1:0];
        res.limited  = clip;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    hist_next[ipid_pkg::NUM_TAPS-1:1] = hist_reg[ipid_pkg::NUM_TAPS-2:0];
                    mac_cmd.start    = 1'b1;
                    mac_cmd.init     = 1'b1;
                    mac_cmd.acc_init = filt_base;
                    mac_cmd.mcand    = diff;
                    mac_cmd.mplier   = w_eff;
                    mac_cmd.nbits    = ipid_pkg::CNT_W'(ipid_pkg::FILT_BITS);
                    mac_cmd.msb_neg  = 1'b0;
                    state_next       = ST_FILT;
                end
            end
            ST_FILT: begin
                if (!mac_stat.busy) begin
                    hist_next[0] = q_full[DW-1:0];
                    tap_next     = '0;
                    state_next   = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                mac_cmd.start    = 1'b1;
                mac_cmd.init     = (tap_reg == '0);
                mac_cmd.acc_init = '0;
                mac_cmd.mcand    = {tap_err[DW-1], tap_err};
                mac_cmd.mplier   = {{(ipid_pkg::MUL_W-ipid_pkg::COEF_W)
                                     {tap_coef[ipid_pkg::COEF_W-1]}}, tap_coef};
                mac_cmd.nbits    = ipid_pkg::CNT_W'(ipid_pkg::COEF_W);
                mac_cmd.msb_neg  = 1'b1;
                state_next       = ST_MUL;
            end
            ST_MUL: begin
                if (!mac_stat.busy) begin
                    if (tap_reg == ipid_pkg::TAP_IDX_W'(ipid_pkg::NUM_TAPS - 1)) begin
                        state_next = ST_DIV;
                    end else begin
                        tap_next   = tap_reg + ipid_pkg::TAP_IDX_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_DIV: begin
                q_next     = q_full[QW-1:0];
                state_next = ST_ADD;
            end
            ST_ADD: begin
                u_next     = {{(UW-DW){out_acc_reg[DW-1]}}, out_acc_reg} +
                             {q_reg[QW-1], q_reg};
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                res.valid = 1'b1;
                if (res_ready) begin
                    out_acc_next = clamp_val[DW-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tap_reg     <= '0;
            hist_reg    <= '0;
            out_acc_reg <= '0;
        end else begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            hist_reg    <= hist_next;
            out_acc_reg <= out_acc_next;
        end
    end

    // Intermediate results
    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        u_reg <= u_next;
    end

endmodule

`default_nettype wire

/* src/incremental_pid_controller_core.sv */
// Incremental (velocity-form) PID controller. Each request carries one signed
// error sample; the block optionally smooths it, keeps the last four errors,
// adds the scaled weighted sum of them to its running output, clamps that to
// plus or minus output_limit and returns the output with a flag that is set
// when the clamp acted. All products run through one bit-serial shift-add
// multiplier, one multiplier bit per cycle, so a new request is accepted only
// after the previous one has finished and its result has entered the output
// register. The result waits there to be taken, so a new request may start
// meanwhile. Registers (APB, byte addresses): 0x00-0x0C coef_b0..coef_b3,
// 0x10 output_limit, 0x14 filter_enable, 0x18 filter_weight. Write them only
// while the block is idle.
`default_nettype none

module incremental_pid_controller_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ipid_pkg::PADDR_W-1:0]        paddr,
    input  logic [ipid_pkg::PDATA_W-1:0]        pwdata,
    output logic [ipid_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ipid_pkg::DATA_W-1:0]  s_error_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ipid_pkg::DATA_W-1:0]  m_drive_value,
    output logic                                m_limited
);

    ipid_pkg::cfg_t      cfg;
    ipid_pkg::mac_cmd_t  mac_cmd;
    ipid_pkg::mac_stat_t mac_stat;
    ipid_pkg::res_t      res;
    logic                res_ready;

    logic                        m_valid_reg, m_valid_next;
    logic [ipid_pkg::DATA_W-1:0] m_drive_reg, m_drive_next;
    logic                        m_limited_reg, m_limited_next;

    ipid_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipid_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .stat    (mac_stat)
    );

    ipid_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_error_sample (s_error_sample),
        .cfg            (cfg),
        .mac_cmd        (mac_cmd),
        .mac_stat       (mac_stat),
        .res            (res),
        .res_ready      (res_ready)
    );

    // Output register: free when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_drive_next   = m_drive_reg;
        m_limited_next = m_limited_reg;
        if (res.valid && res_ready) begin
            m_valid_next   = 1'b1;
            m_drive_next   = res.drive;
            m_limited_next = res.limited;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_drive_reg   <= m_drive_next;
        m_limited_reg <= m_limited_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_value = m_drive_reg;
    assign m_limited     = m_limited_reg;

endmodule

`default_nettype wire

/* src/ipid_checker.sv */
`default_nettype none

module ipid_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [ipid_pkg::DATA_W-1:0] m_drive_value,
    input logic                        m_limited
);

    localparam logic [ipid_pkg::DATA_W-1:0] MOST_NEG = {1'b1, {(ipid_pkg::DATA_W-1){1'b0}}};

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_value) && $stable(m_limited))
        else $error("result changed while stalled");

    // Clamp keeps the output symmetric, so the most negative code never appears
    a_no_most_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_drive_value != MOST_NEG)
        else $error("output outside the symmetric range");

    // One request at a time: input closes right after an acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in work");

    // A result never follows its request in the very next cycle
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready))
        else $error("result appeared too soon after a request");

endmodule

bind incremental_pid_controller_core ipid_checker u_ipid_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RESET_CYCLES    = 11;
    localparam int     HOLD_OFF_CYCLES = 600;
    localparam int     WATCHDOG_LIMIT  = 4000;
    localparam int     DRAIN_CYCLES    = 100;
    localparam int     RANDOM_PHASES   = 8;
    localparam int     PHASE_REQUESTS  = 185;
    localparam longint SCALE           = longint'(1) << ipid_pkg::FRAC_SHIFT;

    // Address 0x1C lies past the last register and must be ignored
    localparam logic [ipid_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic signed [ipid_pkg::DATA_W-1:0] drive;
        logic                               limited;
    } drive_result_t;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #1 aclk = ~aclk;

    // Configuration port
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [ipid_pkg::PADDR_W-1:0]   paddr   = '0;
    logic [ipid_pkg::PDATA_W-1:0]   pwdata  = '0;
    logic [ipid_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    // Request and result channels
    logic                               s_valid        = 1'b0;
    logic                               s_ready;
    logic signed [ipid_pkg::DATA_W-1:0] s_error_sample = '0;
    logic                               m_valid;
    logic                               m_ready        = 1'b0;
    logic signed [ipid_pkg::DATA_W-1:0] m_drive_value;
    logic                               m_limited;

    incremental_pid_controller_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_error_sample (s_error_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive_value  (m_drive_value),
        .m_limited      (m_limited)
    );

    // Controller mirror: configuration and state
    logic signed [ipid_pkg::COEF_W-1:0] coef_cfg [ipid_pkg::NUM_TAPS];
    logic [ipid_pkg::LIMIT_W-1:0]       limit_cfg;
    logic                               filt_en_cfg;
    logic [ipid_pkg::WEIGHT_W-1:0]      weight_cfg;
    logic signed [ipid_pkg::DATA_W-1:0] err_hist [ipid_pkg::NUM_TAPS];
    logic signed [ipid_pkg::DATA_W-1:0] drive_acc;

    drive_result_t expected_drive_q [$];
    int            fail_count   = 0;
    bit            hold_off_req = 1'b0;

    // One controller step: shift history, smooth, weighted sum, accumulate, clamp
    function automatic drive_result_t predict_drive(
        logic signed [ipid_pkg::DATA_W-1:0] err_in);
        longint        err;
        longint        w;
        longint        e_new;
        longint        sum;
        longint        u;
        longint        lim;
        drive_result_t r;

        err = longint'(err_in);
        for (int k = ipid_pkg::NUM_TAPS - 1; k > 0; k--) err_hist[k] = err_hist[k-1];

        // err_hist[0] still holds the previous filtered error here
        if (filt_en_cfg) begin
            w = longint'(weight_cfg);
            if (w > SCALE) w = SCALE;
            e_new = ((SCALE - w) * longint'(err_hist[0]) + w * err) / SCALE;
        end else begin
            e_new = err;
        end
        err_hist[0] = e_new[ipid_pkg::DATA_W-1:0];

        sum = 64'sd0;
        for (int k = 0; k < ipid_pkg::NUM_TAPS; k++)
            sum += longint'(err_hist[k]) * longint'(coef_cfg[k]);
        u = longint'(drive_acc) + sum / SCALE;

        lim       = longint'(limit_cfg);
        r.limited = 1'b0;
        if (u > lim) begin
            u         = lim;
            r.limited = 1'b1;
        end
        if (u < -lim) begin
            u         = -lim;
            r.limited = 1'b1;
        end
        drive_acc = u[ipid_pkg::DATA_W-1:0];
        r.drive   = u[ipid_pkg::DATA_W-1:0];
        return r;
    endfunction

    // Mixed error values: extremes, near zero, full range
    function automatic logic signed [ipid_pkg::DATA_W-1:0] rand_error();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return 16'($urandom_range(0, 511) - 256);
            4:       return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom());
        endcase
    endfunction

    // Present one request and wait for it to be taken
    task automatic send_sample(logic signed [ipid_pkg::DATA_W-1:0] err);
        s_valid        <= 1'b1;
        s_error_sample <= err;
        do @(posedge aclk); while (!s_ready);
        expected_drive_q.push_back(predict_drive(err));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_drive_q.size() != 0);
    endtask

    // Setup then access phase; the register takes the value on the access edge
    task automatic apb_write(logic [ipid_pkg::REG_IDX_W-1:0] idx,
                             logic [ipid_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            ipid_pkg::REG_B0:      coef_cfg[0] = data[ipid_pkg::COEF_W-1:0];
            ipid_pkg::REG_B1:      coef_cfg[1] = data[ipid_pkg::COEF_W-1:0];
            ipid_pkg::REG_B2:      coef_cfg[2] = data[ipid_pkg::COEF_W-1:0];
            ipid_pkg::REG_B3:      coef_cfg[3] = data[ipid_pkg::COEF_W-1:0];
            ipid_pkg::REG_LIMIT:   limit_cfg   = data[ipid_pkg::LIMIT_W-1:0];
            ipid_pkg::REG_FILT_EN: filt_en_cfg = data[0];
            ipid_pkg::REG_WEIGHT:  weight_cfg  = data[ipid_pkg::WEIGHT_W-1:0];
            default:               ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Full register set, junk in the unused upper bits
    task automatic apply_config(
        logic signed [ipid_pkg::COEF_W-1:0] b0, logic signed [ipid_pkg::COEF_W-1:0] b1,
        logic signed [ipid_pkg::COEF_W-1:0] b2, logic signed [ipid_pkg::COEF_W-1:0] b3,
        logic [ipid_pkg::LIMIT_W-1:0] lim, logic en, logic [ipid_pkg::WEIGHT_W-1:0] wt);
        drain_results();
        apb_write(ipid_pkg::REG_B0,      {16'($urandom()), b0});
        apb_write(ipid_pkg::REG_B1,      {16'($urandom()), b1});
        apb_write(ipid_pkg::REG_B2,      {16'($urandom()), b2});
        apb_write(ipid_pkg::REG_B3,      {16'($urandom()), b3});
        apb_write(ipid_pkg::REG_LIMIT,   {17'($urandom()), lim});
        apb_write(ipid_pkg::REG_FILT_EN, {31'($urandom()), en});
        apb_write(ipid_pkg::REG_WEIGHT,  {23'($urandom()), wt});
    endtask

    // Bursts of random length with random gaps, some back to back
    task automatic run_traffic(int n);
        int sent;
        int burst;
        int gap;

        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < n; k++) begin
                send_sample(rand_error());
                sent++;
            end
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 8);
                2:       gap = $urandom_range(1, 90);
                default: gap = $urandom_range(20, 200);
            endcase
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Zero coefficients after reset, and a write past the register map
    task automatic test_reset_state();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        drain_results();
        apb_write(REG_UNMAPPED, '1);
        send_sample(16'sh3039);
    endtask

    // Full-scale errors and coefficients: the increment exceeds the output range
    task automatic test_operand_extremes();
        apply_config(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 15'h7FFF, 1'b0, 9'd256);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        apply_config(16'sd256, 16'sd0, 16'sd0, 16'sd0, 15'h7FFF, 1'b0, 9'd256);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
    endtask

    // Zero limit holds the output at zero, flag set for any non-zero value
    task automatic test_zero_limit();
        apply_config(16'sd256, 16'sd0, 16'sd0, 16'sd0, 15'd0, 1'b0, 9'd256);
        send_sample(16'sd5);
        send_sample(16'sd0);
        send_sample(-16'sd5);
    endtask

    // Smoothing across weights, including those above full scale
    task automatic test_smoothing();
        logic [ipid_pkg::WEIGHT_W-1:0] weights [5] = '{9'd0, 9'd128, 9'd256, 9'd300, 9'd511};

        foreach (weights[i]) begin
            apply_config(16'sd256, 16'sd64, -16'sd32, 16'sd16, 15'h7FFF, 1'b1, weights[i]);
            send_sample(16'sh7FFF);
            send_sample(-16'sd20000);
        end
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        apply_config(16'sd300, -16'sd200, 16'sd50, 16'sd10, 15'd20000, 1'b1, 9'd64);
        hold_off_req = 1'b1;
        for (int k = 0; k < 24; k++) send_sample(rand_error());
        drain_results();
    endtask

    // Random phases, each with its own configuration; the first two at the extremes
    task automatic test_random_phases();
        logic signed [ipid_pkg::COEF_W-1:0] c [ipid_pkg::NUM_TAPS];
        logic [ipid_pkg::LIMIT_W-1:0]       lim;
        logic                               en;
        logic [ipid_pkg::WEIGHT_W-1:0]      wt;

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                foreach (c[k]) c[k] = 16'sh7FFF;
                lim = 15'h7FFF;
                en  = 1'b1;
                wt  = 9'd511;
            end else if (phase == 1) begin
                foreach (c[k]) c[k] = 16'sh8000;
                lim = 15'd0;
                en  = 1'b0;
                wt  = 9'd0;
            end else begin
                foreach (c[k]) begin
                    case ($urandom_range(0, 3))
                        0, 1:    c[k] = 16'($urandom_range(0, 1023) - 512);
                        2:       c[k] = 16'($urandom());
                        default: c[k] = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
                    endcase
                end
                case ($urandom_range(0, 5))
                    0:       lim = 15'h7FFF;
                    1:       lim = 15'd0;
                    2:       lim = 15'($urandom_range(0, 300));
                    default: lim = 15'($urandom());
                endcase
                en = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0:       wt = 9'd256;
                    1:       wt = 9'd0;
                    default: wt = 9'($urandom());
                endcase
            end
            apply_config(c[0], c[1], c[2], c[3], lim, en, wt);
            run_traffic(PHASE_REQUESTS);
        end
    endtask

    // Result sink: random ready pattern, plus the long hold-off on request
    initial begin : result_sink
        int mode;
        int run;

        wait (aresetn);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                run  = $urandom_range(1, 40);
                repeat (run) begin
                    case (mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= ($urandom_range(0, 3) != 0);
                        2:       m_ready <= ($urandom_range(0, 1) != 0);
                        default: m_ready <= ($urandom_range(0, 7) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge aclk) begin : result_check
        drive_result_t exp_r;

        if (aresetn && m_valid && m_ready) begin
            if (expected_drive_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result: expected none, actual drive %0d limited %0b",
                         $time, m_drive_value, m_limited);
            end else begin
                exp_r = expected_drive_q.pop_front();
                if (m_drive_value !== exp_r.drive) begin
                    fail_count++;
                    $display("%0t: drive_value mismatch: expected %0d, actual %0d",
                             $time, exp_r.drive, m_drive_value);
                end
                if (m_limited !== exp_r.limited) begin
                    fail_count++;
                    $display("%0t: limited mismatch: expected %0b, actual %0b",
                             $time, exp_r.limited, m_limited);
                end
            end
        end
    end

    // Watchdog: too long without any request or result moving
    initial begin : watchdog
        int idle_count;

        idle_count = 0;
        while (idle_count < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle_count = 0;
            else
                idle_count++;
        end
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, expected_drive_q.size());
        $display("incremental_pid_controller_core regression: fail");
        $finish;
    end

    // Sequence of tests
    initial begin : main_sequence
        foreach (coef_cfg[k]) coef_cfg[k] = '0;
        foreach (err_hist[k]) err_hist[k] = '0;
        limit_cfg   = ipid_pkg::LIMIT_RST;
        filt_en_cfg = 1'b0;
        weight_cfg  = ipid_pkg::WEIGHT_RST;
        drive_acc   = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_operand_extremes();
        test_zero_limit();
        test_smoothing();
        test_backpressure();
        test_random_phases();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("incremental_pid_controller_core regression: pass");
        else
            $display("incremental_pid_controller_core regression: fail");
        $finish;
    end

endmodule
